@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers shared by the deframer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge, off while arst_n is low
`define ASSERT_IMPLY(label, cond, prop, msg) \
	`ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

@@ rtl/core/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// shared codes, token type and crc step for the dle frame receiver
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam logic [7:0] DLE_CODE = 8'h10;
	localparam logic [7:0] STX_CODE = 8'h02;
	localparam logic [7:0] ETX_CODE = 8'h03;
	localparam logic [7:0] BROADCAST_ADDR = 8'hFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] HEADER_BYTES = 16'd8;

	localparam logic [7:0] BOARD_ADDR_RESET = 8'd1;
	localparam logic [15:0] MAX_LEN_RESET = 16'd288;

	localparam logic REG_BOARD_ADDR = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_GOOD    = 3'd1,
		KIND_CRC_ERR = 3'd2,
		KIND_LEN_ERR = 3'd3,
		KIND_DROPPED = 3'd4
	} out_kind_t;

	typedef enum logic [1:0] {
		TOK_HDR  = 2'd0,
		TOK_BODY = 2'd1,
		TOK_DROP = 2'd2,
		TOK_END  = 2'd3
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  data;
		logic [2:0]  idx;
		logic        emit;
		logic        len_err;
		logic [15:0] plen;
	} tok_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/dle_frame_receiver_crc16.sv @@
// ----------------------------------------------------------------------------
// dle_frame_receiver_crc16
// dle stx/etx deframer with header checks and crc-16 (poly 0x1021, init 0)
//
// channel  dir  handshake           content
// s_*      in   s_tvalid/s_tready   tdata[7:0] rx_byte
// m_*      out  m_tvalid/m_tready   tdata payload/header fields, tuser out_kind
// cfg_*    in   cfg_valid/cfg_ready index 0 board_address, 1 max_length
//
// one raw byte per cycle while s_tready is high; the front end decides each
// byte in the cycle it arrives, the back end takes tokens from a two-entry
// queue, runs the crc step and loads the result register
// a byte's result is held in a queue entry, then in the result register
// reset clears framing state and loads the register defaults
// a stalled m_tready fills the queue, then s_tready drops
// ----------------------------------------------------------------------------
module dle_frame_receiver_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // payload_byte, source_addr, dest_addr, frame_type, command, payload_len
	output logic [2:0]  m_tuser,   // out_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  board_q;
	logic [15:0] maxlen_q;

	logic          q_ready;
	logic          push;
	dfr_pkg::tok_t push_tok;
	logic          q_valid;
	logic          pop;
	dfr_pkg::tok_t head;

	assign cfg_ready = 1'b1;
	assign s_tready  = q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q  <= dfr_pkg::BOARD_ADDR_RESET;
			maxlen_q <= dfr_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dfr_pkg::REG_BOARD_ADDR: board_q  <= cfg_data[7:0];
				dfr_pkg::REG_MAX_LEN:    maxlen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid && q_ready),
		.byte_data  (s_tdata),
		.board_addr (board_q),
		.max_len    (maxlen_q),
		.push       (push),
		.tok        (push_tok)
	);

	dfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.head     (head)
	);

	dfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok       (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

@@ rtl/core/dfr_front.sv @@
// ----------------------------------------------------------------------------
// dfr_front
// start hunt, dle destuffing and header checks; one token per in-frame marker or destuffed byte
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic [7:0]      byte_data,
	input  logic [7:0]      board_addr,
	input  logic [15:0]     max_len,
	output logic            push,
	output dfr_pkg::tok_t   tok
);

	logic        in_frame_q;
	logic        dle_q;
	logic [16:0] cnt_q;
	logic [15:0] len_q;

	logic        in_frame_d;
	logic        dle_d;
	logic [16:0] cnt_d;
	logic [15:0] len_d;
	logic        gen;
	logic [15:0] fl;
	logic [16:0] lim;
	logic        bad;

	assign fl  = {len_q[15:8], byte_data};
	assign lim = {1'b0, len_q} + 17'd2;

	always_comb begin
		in_frame_d = in_frame_q;
		dle_d      = dle_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		gen        = 1'b0;
		bad        = 1'b0;
		tok        = '0;
		tok.kind   = dfr_pkg::TOK_HDR;
		tok.data   = byte_data;
		if (!in_frame_q) begin
			if (byte_data == dfr_pkg::DLE_CODE) begin
				dle_d = 1'b1;
			end else if (byte_data == dfr_pkg::STX_CODE && dle_q) begin
				in_frame_d = 1'b1;
				dle_d      = 1'b0;
				cnt_d      = '0;
				len_d      = '0;
			end else begin
				dle_d = 1'b0;
			end
		end else if (byte_data == dfr_pkg::DLE_CODE && !dle_q) begin
			dle_d = 1'b1;
		end else if (dle_q && byte_data == dfr_pkg::STX_CODE) begin
			dle_d    = 1'b0;
			cnt_d    = '0;
			len_d    = '0;
			gen      = 1'b1;
			tok.kind = dfr_pkg::TOK_DROP;
		end else if (dle_q && byte_data == dfr_pkg::ETX_CODE) begin
			in_frame_d  = 1'b0;
			dle_d       = 1'b0;
			cnt_d       = '0;
			len_d       = '0;
			gen         = 1'b1;
			tok.kind    = dfr_pkg::TOK_END;
			tok.len_err = (cnt_q != lim);
			tok.plen    = (cnt_q >= 17'd2) ? len_q - dfr_pkg::HEADER_BYTES : 16'd0;
		end else begin
			dle_d = 1'b0;
			gen   = 1'b1;
			if (cnt_q >= 17'd2 && cnt_q >= lim) begin
				bad = 1'b1;
			end
			if (cnt_q == 17'd1 && (fl < dfr_pkg::HEADER_BYTES || fl > max_len)) begin
				bad = 1'b1;
			end
			if ((cnt_q == 17'd3 || cnt_q == 17'd5) && byte_data != 8'h00) begin
				bad = 1'b1;
			end
			if (cnt_q == 17'd4 && byte_data != board_addr
					&& byte_data != dfr_pkg::BROADCAST_ADDR) begin
				bad = 1'b1;
			end
			if (bad) begin
				in_frame_d = 1'b0;
				cnt_d      = '0;
				len_d      = '0;
				tok.kind   = dfr_pkg::TOK_DROP;
			end else begin
				if (cnt_q == 17'd0) begin
					len_d = {byte_data, 8'h00};
				end else if (cnt_q == 17'd1) begin
					len_d = fl;
				end
				cnt_d    = cnt_q + 17'd1;
				tok.idx  = cnt_q[2:0];
				tok.kind = (cnt_q < 17'd8) ? dfr_pkg::TOK_HDR : dfr_pkg::TOK_BODY;
				tok.emit = (cnt_q >= 17'd10);
			end
		end
	end

	assign push = byte_valid && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			dle_q      <= 1'b0;
			cnt_q      <= '0;
			len_q      <= '0;
		end else if (byte_valid) begin
			in_frame_q <= in_frame_d;
			dle_q      <= dle_d;
			cnt_q      <= cnt_d;
			len_q      <= len_d;
		end
	end

	// leaving a frame always hands a drop or end token to the back end
	`ASSERT_IMPLY(a_leave_has_token, $fell(in_frame_q), $past(push), "frame left without token")

endmodule

@@ rtl/core/dfr_queue.sv @@
// ----------------------------------------------------------------------------
// dfr_queue
// two-entry token queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dfr_pkg::tok_t   push_tok,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output dfr_pkg::tok_t   head
);

	dfr_pkg::tok_t mem_q [dfr_pkg::QUEUE_DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign ready = (count_q != 2'(dfr_pkg::QUEUE_DEPTH));
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`ASSERT_IMPLY(a_no_pop_empty, pop, count_q != 2'd0, "pop from empty queue")
	`ASSERT_IMPLY(a_no_push_full, push && !pop, count_q != 2'(dfr_pkg::QUEUE_DEPTH),
		"push into full queue")

endmodule

@@ rtl/core/dfr_back.sv @@
// ----------------------------------------------------------------------------
// dfr_back
// crc, two-byte hold-back, header capture and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tok_valid,
	input  dfr_pkg::tok_t   tok,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [55:0]     m_tdata,
	output logic [2:0]      m_tuser
);

	logic [15:0] crc_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [7:0]  src_q;
	logic [7:0]  dst_q;
	logic [7:0]  typ_q;
	logic [7:0]  cmd_q;
	logic        ovalid_q;
	logic [55:0] odata_q;
	logic [2:0]  okind_q;

	logic [7:0]  crc_in;
	logic [15:0] crc_next;
	logic        res;
	logic [55:0] rdata;
	dfr_pkg::out_kind_t rkind;

	assign pop      = tok_valid && (!ovalid_q || m_tready);
	assign crc_in   = (tok.kind == dfr_pkg::TOK_HDR) ? tok.data : held0_q;
	assign crc_next = dfr_pkg::crc_step(crc_q, crc_in);

	always_comb begin
		res   = 1'b0;
		rdata = '0;
		rkind = dfr_pkg::KIND_PAYLOAD;
		unique case (tok.kind)
			dfr_pkg::TOK_HDR: begin
				res = 1'b0;
			end
			dfr_pkg::TOK_BODY: begin
				res        = tok.emit;
				rdata[7:0] = held0_q;
			end
			dfr_pkg::TOK_DROP: begin
				res   = 1'b1;
				rkind = dfr_pkg::KIND_DROPPED;
			end
			dfr_pkg::TOK_END: begin
				res   = 1'b1;
				rdata = {tok.plen, cmd_q, typ_q, dst_q, src_q, 8'h00};
				if (tok.len_err) begin
					rkind = dfr_pkg::KIND_LEN_ERR;
				end else if ({held0_q, held1_q} == crc_q) begin
					rkind = dfr_pkg::KIND_GOOD;
				end else begin
					rkind = dfr_pkg::KIND_CRC_ERR;
				end
			end
			default: begin
				res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= '0;
			held0_q <= '0;
			held1_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			typ_q   <= '0;
			cmd_q   <= '0;
		end else if (pop) begin
			unique case (tok.kind)
				dfr_pkg::TOK_HDR: begin
					crc_q <= crc_next;
					case (tok.idx)
						3'd2: src_q <= tok.data;
						3'd4: dst_q <= tok.data;
						3'd6: typ_q <= tok.data;
						3'd7: cmd_q <= tok.data;
						default: ;
					endcase
				end
				dfr_pkg::TOK_BODY: begin
					if (tok.emit) begin
						crc_q <= crc_next;
					end
					held0_q <= held1_q;
					held1_q <= tok.data;
				end
				default: begin
					crc_q   <= '0;
					held0_q <= '0;
					held1_q <= '0;
					src_q   <= '0;
					dst_q   <= '0;
					typ_q   <= '0;
					cmd_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop && res) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res) begin
			odata_q <= rdata;
			okind_q <= rkind;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = okind_q;

	`ASSERT_IMPLY(a_drop_is_blank, m_tvalid && m_tuser == dfr_pkg::KIND_DROPPED,
		m_tdata == 56'd0, "dropped result carries data")

endmodule
